// ===== design/sphere_box_classify_macros.svh =====
// Assertion helpers; the using module provides clk_i and rst_ni.
`ifndef SPHERE_BOX_CLASSIFY_MACROS_SVH
`define SPHERE_BOX_CLASSIFY_MACROS_SVH

// Same-cycle implication.
`define SBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sphere_box_classify: same-cycle check failed");

// Next-cycle implication.
`define SBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sphere_box_classify: next-cycle check failed");

`endif

// ===== design/sbc_pkg.sv =====
`default_nettype none

package sbc_pkg;

  localparam int CoordW  = 16;
  localparam int CentreW = 29;
  localparam int RadiusW = 24;
  localparam int CfgW    = 29;
  localparam int CfgIdxW = 2;

  // A distance of at least 2**MagW always squares past any radius squared.
  localparam int MagW = RadiusW;
  localparam int SqW  = 2 * MagW;
  localparam int SumW = SqW + 2;

  // 8 fractional bits
  localparam int FracOne = 256;
  localparam int Half    = 128;

  localparam logic [CfgIdxW-1:0] REG_CENTRE_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_Z = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_RADIUS   = 2'd3;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_PARTIAL = 2'd1,
    CLS_INSIDE  = 2'd2
  } overlap_class_e;

  // Squared nearest/farthest distance on one axis; *_big means >= 2**SqW.
  typedef struct packed {
    logic           near_big;
    logic [SqW-1:0] near_sq;
    logic           far_big;
    logic [SqW-1:0] far_sq;
  } axis_sq_t;

endpackage

`default_nettype wire

// ===== design/sbc_axis.sv =====
`default_nettype none

// One axis: bounds, differences, magnitudes, squares. Four register stages.
module sbc_axis
  import sbc_pkg::*;
#(
  parameter int BOX_EDGE = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic signed [CoordW-1:0]  coord_i,
  input  wire logic signed [CentreW-1:0] centre_i,
  output axis_sq_t                       sq_o
);

  localparam int EdgeFix = BOX_EDGE * FracOne;
  localparam int EdgeW   = $clog2(EdgeFix + 1) + 1;
  localparam int BaseW   = CoordW + EdgeW;
  localparam int PosW    = BaseW + 1;
  localparam int DiffW   = ((PosW > CentreW) ? PosW : CentreW) + 1;
  localparam logic signed [EdgeW-1:0] EdgeK = EdgeW'(EdgeFix);

  logic signed [BaseW-1:0] base;
  logic signed [PosW-1:0]  lo_d, hi_d, lo_q, hi_q;
  logic signed [DiffW-1:0] dlo_d, dhi_d, dlo_q, dhi_q;
  logic [DiffW-1:0]        mag_lo, mag_hi, near_mag, far_mag;
  logic                    below, above;
  logic                    near_big_q, far_big_q;
  logic [MagW-1:0]         near_q, far_q;
  axis_sq_t                sq_q;

  // stage 1: voxel-centre bounds of the chunk
  assign base = coord_i * EdgeK;
  assign lo_d = PosW'(base) + PosW'(Half);
  assign hi_d = PosW'(base) + PosW'(EdgeFix - Half);

  // stage 2: centre minus each bound
  assign dlo_d = DiffW'(centre_i) - DiffW'(lo_q);
  assign dhi_d = DiffW'(centre_i) - DiffW'(hi_q);

  // stage 3: nearest and farthest magnitudes; ties keep the min bound
  assign mag_lo   = dlo_q[DiffW-1] ? DiffW'(-dlo_q) : DiffW'(dlo_q);
  assign mag_hi   = dhi_q[DiffW-1] ? DiffW'(-dhi_q) : DiffW'(dhi_q);
  assign below    = dlo_q[DiffW-1];
  assign above    = !dhi_q[DiffW-1] && (dhi_q != '0);
  assign near_mag = below ? mag_lo : (above ? mag_hi : '0);
  assign far_mag  = (mag_lo < mag_hi) ? mag_hi : mag_lo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      dlo_q      <= dlo_d;
      dhi_q      <= dhi_d;
      near_big_q <= |near_mag[DiffW-1:MagW];
      far_big_q  <= |far_mag[DiffW-1:MagW];
      near_q     <= near_mag[MagW-1:0];
      far_q      <= far_mag[MagW-1:0];
      // stage 4: squares
      sq_q.near_big <= near_big_q;
      sq_q.far_big  <= far_big_q;
      sq_q.near_sq  <= SqW'(near_q * near_q);
      sq_q.far_sq   <= SqW'(far_q * far_q);
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ===== design/sphere_box_classify.sv =====
// Channel  Direction  Ports                                   Beat
// in       input      in_valid_i / in_ready_o                 box_x_i, box_y_i, box_z_i
// out      output     out_valid_o / out_ready_i               overlap_class_o
// cfg      input      cfg_we_i, cfg_idx_i, cfg_data_i         one register write
//
// Five register stages: bounds, differences, magnitudes, squares, sum and compare.
// One beat per cycle is sustained while the output is not stalled.
// Radius squared is registered off the radius config register.
// A stalled output freezes every stage; in_ready_o is low only while out is stalled.
// Reset clears the valid bits and the config registers.
`default_nettype none

`include "sphere_box_classify_macros.svh"

module sphere_box_classify
  import sbc_pkg::*;
#(
  parameter int BOX_EDGE = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgW-1:0]           cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [CoordW-1:0]  box_x_i,
  input  wire logic signed [CoordW-1:0]  box_y_i,
  input  wire logic signed [CoordW-1:0]  box_z_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     overlap_class_o
);

  localparam int Depth = 5;

  logic signed [CentreW-1:0] centre_x_q, centre_y_q, centre_z_q;
  logic [RadiusW-1:0]        radius_q;
  logic [SqW-1:0]            r2_q;
  logic [Depth-1:0]          v_q, v_d;
  logic                      en;
  axis_sq_t                  sq_x, sq_y, sq_z;
  logic [SumW-1:0]           near_sum, far_sum;
  logic                      near_out, far_out;
  overlap_class_e            cls_d, cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      centre_z_q <= '0;
      radius_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTRE_X: centre_x_q <= cfg_data_i;
        REG_CENTRE_Y: centre_y_q <= cfg_data_i;
        REG_CENTRE_Z: centre_z_q <= cfg_data_i;
        REG_RADIUS:   radius_q   <= cfg_data_i[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= SqW'(radius_q * radius_q);
  end

  // whole pipe moves unless the output beat is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign v_d        = {v_q[Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  sbc_axis #(.BOX_EDGE(BOX_EDGE)) u_axis_x (
    .clk_i, .en_i(en), .coord_i(box_x_i), .centre_i(centre_x_q), .sq_o(sq_x)
  );
  sbc_axis #(.BOX_EDGE(BOX_EDGE)) u_axis_y (
    .clk_i, .en_i(en), .coord_i(box_y_i), .centre_i(centre_y_q), .sq_o(sq_y)
  );
  sbc_axis #(.BOX_EDGE(BOX_EDGE)) u_axis_z (
    .clk_i, .en_i(en), .coord_i(box_z_i), .centre_i(centre_z_q), .sq_o(sq_z)
  );

  // any oversized axis term already exceeds every radius squared
  assign near_sum = SumW'(sq_x.near_sq) + SumW'(sq_y.near_sq) + SumW'(sq_z.near_sq);
  assign far_sum  = SumW'(sq_x.far_sq) + SumW'(sq_y.far_sq) + SumW'(sq_z.far_sq);
  assign near_out = sq_x.near_big || sq_y.near_big || sq_z.near_big
                    || (near_sum > SumW'(r2_q));
  assign far_out  = sq_x.far_big || sq_y.far_big || sq_z.far_big
                    || (far_sum > SumW'(r2_q));

  always_comb begin
    if (near_out) begin
      cls_d = CLS_OUTSIDE;
    end else if (far_out) begin
      cls_d = CLS_PARTIAL;
    end else begin
      cls_d = CLS_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_q <= cls_d;
    end
  end

  assign out_valid_o     = v_q[Depth-1];
  assign overlap_class_o = cls_q;

  `SBC_ASSERT_NOW(a_stall_only_on_out, !in_ready_o, out_valid_o && !out_ready_i)
  `SBC_ASSERT_NXT(a_beat_enters, in_valid_i && in_ready_o, v_q[0])
  `SBC_ASSERT_NXT(a_pipe_frozen, !in_ready_o, $stable(v_q))
  `SBC_ASSERT_NOW(a_class_legal, out_valid_o,
                  overlap_class_o == CLS_OUTSIDE || overlap_class_o == CLS_PARTIAL
                  || overlap_class_o == CLS_INSIDE)

endmodule

`default_nettype wire
